>>> hdl/spsm_pkg.sv
// Shared types, constants and helpers for the stream pattern search/match unit.
// No dependencies.
`timescale 1ns / 1ps

package spsm_pkg;

  localparam int unsigned CharW     = 16;
  localparam int unsigned NumPatChr = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LenW      = 5;

  localparam logic [LenW-1:0] CntSat = 5'd17;

  localparam logic [CharW-1:0] AsciiUpperA = 16'h0041;
  localparam logic [CharW-1:0] AsciiUpperZ = 16'h005A;
  localparam logic [CharW-1:0] AsciiCaseOfs = 16'h0020;

  localparam logic [CfgIdxW-1:0] RegCaseIns  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWhole    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPatLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPatWord0 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPatWord1 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPatWord2 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPatWord3 = 3'd6;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } in_t;

  typedef struct packed {
    logic verdict;
    logic final_res;
  } out_t;

  typedef struct packed {
    logic                            case_insensitive;
    logic                            whole_match;
    logic [LenW-1:0]                 pattern_length;
    logic [NumPatChr-1:0][CharW-1:0] pattern;
  } cfg_t;

  function automatic logic [CharW-1:0] fold_char(logic [CharW-1:0] c, logic ci);
    if (ci && (c >= AsciiUpperA) && (c <= AsciiUpperZ)) begin
      return c + AsciiCaseOfs;
    end
    return c;
  endfunction

endpackage

>>> hdl/spsm_core.sv
// Match core: character window, stream counter and flags, and combinational pattern compare.
// Depends on spsm_pkg.
`timescale 1ns / 1ps

module spsm_core #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spsm_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  spsm_pkg::in_t  in_i,
  output spsm_pkg::out_t res_o
);
  import spsm_pkg::*;

  localparam int unsigned WinDepth = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int unsigned IdxW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  logic [CharW-1:0] recent_q [WinDepth];
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic             found_q, found_d;
  logic             mism_q, mism_d;

  logic [CharW-1:0] wnd [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  cnt_new;
  logic [CharW-1:0] c_fold;
  logic             hit;
  logic             verdict;

  always_comb begin
    wnd[0] = in_i.char_code;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      wnd[k] = recent_q[k-1];
    end
  end

  always_comb begin
    logic             en;
    logic [LenW-1:0]  sel;
    len     = (cfg_i.pattern_length > MaxLen) ? MaxLen : cfg_i.pattern_length;
    cnt_new = (cnt_q < CntSat) ? cnt_q + 5'd1 : CntSat;
    c_fold  = fold_char(in_i.char_code, cfg_i.case_insensitive);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      en    = LenW'(i) < len;
      sel   = len - LenW'(i) - 5'd1;
      ok[i] = !en || (fold_char(cfg_i.pattern[i], cfg_i.case_insensitive) ==
                      fold_char(wnd[sel[IdxW-1:0]], cfg_i.case_insensitive));
    end
    hit = &ok;

    found_d = found_q;
    mism_d  = mism_q;
    if (cfg_i.whole_match) begin
      if ((cnt_q >= len) ||
          (fold_char(cfg_i.pattern[cnt_q[3:0]], cfg_i.case_insensitive) != c_fold)) begin
        mism_d = 1'b1;
      end
      verdict = !mism_d && (!in_i.last_char || (cnt_new == len));
    end else begin
      if ((cnt_new >= len) && hit) begin
        found_d = 1'b1;
      end
      verdict = found_d;
    end

    cnt_d = cnt_new;
    if (in_i.last_char) begin
      cnt_d   = '0;
      found_d = 1'b0;
      mism_d  = 1'b0;
    end
  end

  assign res_o.verdict   = verdict;
  assign res_o.final_res = in_i.last_char;

  // window holds raw characters; entries older than the stream are never compared
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      recent_q[0] <= in_i.char_code;
      for (int k = 1; k < WinDepth; k++) begin
        recent_q[k] <= recent_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
      mism_q  <= 1'b0;
    end else if (accept_i) begin
      cnt_q   <= cnt_d;
      found_q <= found_d;
      mism_q  <= mism_d;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntSat)
    else $error("character count beyond saturation");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_i.last_char |=> (cnt_q == '0) && !found_q && !mism_q)
    else $error("stream state not cleared after last character");

endmodule

>>> hdl/spsm_skid.sv
// Two-entry output buffer: result register plus skid register.
// Depends on spsm_pkg.
`timescale 1ns / 1ps

module spsm_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spsm_pkg::out_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spsm_pkg::out_t out_data_o
);
  import spsm_pkg::*;

  out_t main_q, skid_q;
  logic main_vld_q, skid_vld_q;
  logic pop;

  assign pop = main_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (main_vld_q && !pop) begin
      if (push_i) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      main_vld_q <= 1'b1;
      skid_vld_q <= push_i;
    end else begin
      main_vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_vld_q && !pop) begin
      if (push_i) begin
        skid_q <= push_data_i;
      end
    end else if (skid_vld_q) begin
      main_q <= skid_q;
      if (push_i) begin
        skid_q <= push_data_i;
      end
    end else if (push_i) begin
      main_q <= push_data_i;
    end
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held without result entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("transaction pushed into full buffer");

endmodule

>>> hdl/stream_pattern_search_match_unit.sv
// Top level of the stream pattern search/match unit: config registers, core, output buffer.
// Depends on spsm_pkg, spsm_core, spsm_skid.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o  | in_data_i   (char_code, last_char)
//   out     | output    | out_valid_o/out_stall_i| out_data_o  (verdict, final_res)
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while in_stall_o is low; a result is registered in the output buffer.
// The compare over the whole character window completes in the accepting cycle.
// A two-entry output buffer keeps input flowing while the output is stalled;
// in_stall_o rises only when both entries are occupied.
// Reset clears config registers and stream state; no clearing pass.
`timescale 1ns / 1ps

module stream_pattern_search_match_unit #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  spsm_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output spsm_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [spsm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [spsm_pkg::CfgDataW-1:0]     cfg_data_i
);
  import spsm_pkg::*;

  logic                       case_ins_q;
  logic                       whole_q;
  logic [LenW-1:0]            pat_len_q;
  logic [3:0][CfgDataW-1:0]   pat_words_q;

  cfg_t cfg;
  out_t res;
  logic accept;
  logic full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_ins_q  <= 1'b0;
      whole_q     <= 1'b0;
      pat_len_q   <= '0;
      pat_words_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCaseIns:  case_ins_q     <= cfg_data_i[0];
        RegWhole:    whole_q        <= cfg_data_i[0];
        RegPatLen:   pat_len_q      <= cfg_data_i[LenW-1:0];
        RegPatWord0: pat_words_q[0] <= cfg_data_i;
        RegPatWord1: pat_words_q[1] <= cfg_data_i;
        RegPatWord2: pat_words_q[2] <= cfg_data_i;
        RegPatWord3: pat_words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.case_insensitive = case_ins_q;
  assign cfg.whole_match      = whole_q;
  assign cfg.pattern_length   = pat_len_q;
  assign cfg.pattern          = pat_words_q;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  spsm_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .accept_i(accept),
    .in_i    (in_data_i),
    .res_o   (res)
  );

  spsm_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
